FILE: rtl/vecc_pkg.sv
// shared types and constants of the voronoi edge cell classifier
// no dependencies
package vecc_pkg;

  localparam int unsigned POS_W     = 8;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned DIST_W    = 17;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_APPEND   = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_SQ = 2'd2;

  localparam logic [ID_W-1:0]   START_ID_RST = 8'd1;
  localparam logic [ID_W-1:0]   GOAL_ID_RST  = 8'd2;
  localparam logic [DIST_W-1:0] CLEAR_SQ_RST = 17'd9;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [ID_W-1:0]  obstacle_id;
    logic             cell_free;
  } req_t;

  typedef struct packed {
    logic              status;
    logic              mark_blocked;
    logic              is_edge;
    logic              nearest_valid;
    logic [ID_W-1:0]   nearest_id;
    logic [DIST_W-1:0] nearest_dist_sq;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic edge_hit;
    logic stop;
  } trk_flags_t;

endpackage

FILE: rtl/vecc_stream_if.sv
// valid/ready channel carrying one request or one result
// payload type comes from the instance, normally a vecc_pkg struct
interface vecc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/vecc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module vecc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/vecc_dist_cell.sv
// chain of four cells that turns a stored point into its squared distance
// and the scaled copies the tracker compares; uses vecc_pkg
module vecc_dist_cell
  import vecc_pkg::*;
#(
  parameter int unsigned CW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [CW-1:0]          cell_x_i,
  input  logic [CW-1:0]          cell_y_i,
  input  logic [CW-1:0]          pt_x_i,
  input  logic [CW-1:0]          pt_y_i,
  input  logic [ID_W-1:0]        pt_id_i,
  output logic                   valid_o,
  output logic                   busy_o,
  output logic [2*CW:0]          d_o,
  output logic [2*CW+4:0]        d9_o,
  output logic [2*CW+7:0]        d100_o,
  output logic [2*CW+8:0]        d169_o,
  output logic [ID_W-1:0]        id_o
);
  localparam int unsigned DW = 2 * CW + 1;

  logic [3:0]      vld_q;
  logic [CW-1:0]   dx_q, dy_q;
  logic [2*CW-1:0] dx2_q, dy2_q;
  logic [DW-1:0]   d_q, dd_q;
  logic [DW+3:0]   d9_q;
  logic [DW+6:0]   d100_q;
  logic [DW+7:0]   d169_q;
  logic [ID_W-1:0] id_a_q, id_b_q, id_c_q, id_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= (cell_x_i > pt_x_i) ? cell_x_i - pt_x_i : pt_x_i - cell_x_i;
    dy_q   <= (cell_y_i > pt_y_i) ? cell_y_i - pt_y_i : pt_y_i - cell_y_i;
    id_a_q <= pt_id_i;
    dx2_q  <= (2*CW)'(dx_q) * (2*CW)'(dx_q);
    dy2_q  <= (2*CW)'(dy_q) * (2*CW)'(dy_q);
    id_b_q <= id_a_q;
    d_q    <= DW'(dx2_q) + DW'(dy2_q);
    id_c_q <= id_b_q;
    dd_q   <= d_q;
    d9_q   <= (DW+4)'(d_q) * (DW+4)'(9);
    d100_q <= (DW+7)'(d_q) * (DW+7)'(100);
    d169_q <= (DW+8)'(d_q) * (DW+8)'(169);
    id_d_q <= id_c_q;
  end

  assign valid_o = vld_q[3];
  assign busy_o  = |vld_q;
  assign d_o     = dd_q;
  assign d9_o    = d9_q;
  assign d100_o  = d100_q;
  assign d169_o  = d169_q;
  assign id_o    = id_d_q;
endmodule

FILE: rtl/vecc_track_cell.sv
// last cell of the chain: nearest point tracking with hysteresis and edge test
// uses vecc_pkg
module vecc_track_cell
  import vecc_pkg::*;
#(
  parameter int unsigned CW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [2*CW:0]     d_i,
  input  logic [2*CW+4:0]   d9_i,
  input  logic [2*CW+7:0]   d100_i,
  input  logic [2*CW+8:0]   d169_i,
  input  logic [ID_W-1:0]   id_i,
  input  logic [DIST_W-1:0] clear_sq_i,
  output trk_flags_t        flags_o,
  output logic [ID_W-1:0]   mid_o,
  output logic [2*CW:0]     m_o
);
  localparam int unsigned DW = 2 * CW + 1;

  logic            valid_q, edge_q, stop_q;
  logic            valid_d, edge_d, stop_d;
  logic [DW-1:0]   m_q, m_d;
  logic [DW+6:0]   m100_q, m100_d;
  logic [ID_W-1:0] mid_q, mid_d;
  logic            same_near, clear_near, tie, too_close, take;
  logic [DW+1:0]   m4;

  assign m4         = {m_q, 2'b00};
  assign same_near  = (d_i < m_q) && (id_i == mid_q);
  assign clear_near = d169_i < (DW+8)'(m100_q);
  assign tie        = (id_i != mid_q) && ((DW+2)'(d_i) < m4) && ((DW+4)'(m4) < d9_i);
  assign too_close  = DIST_W'(d_i) < clear_sq_i;
  assign take       = !valid_q || same_near || clear_near;

  always_comb begin
    valid_d = valid_q;
    edge_d  = edge_q;
    stop_d  = stop_q;
    m_d     = m_q;
    m100_d  = m100_q;
    mid_d   = mid_q;
    if (start_i) begin
      valid_d = 1'b0;
      edge_d  = 1'b0;
      stop_d  = 1'b0;
    end else if (step_i && !stop_q) begin
      if (take) begin
        valid_d = 1'b1;
        edge_d  = 1'b0;
        m_d     = d_i;
        m100_d  = d100_i;
        if (!valid_q || !same_near) begin
          mid_d = id_i;
        end
      end else if (tie) begin
        edge_d = !too_close;
        stop_d = too_close;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      edge_q  <= 1'b0;
      stop_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      edge_q  <= edge_d;
      stop_q  <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    m100_q <= m100_d;
    mid_q  <= mid_d;
  end

  assign flags_o = '{valid: valid_q, edge_hit: edge_q, stop: stop_q};
  assign mid_o   = mid_q;
  assign m_o     = m_q;
endmodule

FILE: rtl/voronoi_edge_cell_classifier.sv
// voronoi edge cell classifier top level: point store, walk control, result registers
// clear and append: result registered in res_q then out_q, one request per cycle while results drain
// classify: walks the N stored points, one point per cycle from the ram read port
// reset clears the point count and walk state and loads the config defaults; ram contents are not reset
// uses vecc_pkg, vecc_stream_if, vecc_ram, vecc_dist_cell, vecc_track_cell
module voronoi_edge_cell_classifier
  import vecc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  vecc_stream_if.sink          req,
  vecc_stream_if.source        rsp
);
  localparam int unsigned CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam int unsigned DW    = 2 * CW + 1;
  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned RAM_W = 2 * CW + ID_W;

  state_e            state_q, state_d;
  logic [ID_W-1:0]   start_id_q, goal_id_q;
  logic [DIST_W-1:0] clear_sq_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CW-1:0]     cell_x_q, cell_y_q;
  logic              rdv_q;
  rsp_t              res_q, res_d;
  logic              res_pend_q, res_pend_d;
  rsp_t              out_q;
  logic              out_valid_q;

  logic              accept, move, issue, walk_done, trk_start, store_full;
  logic [RAM_W-1:0]  wdata, rdata;
  logic              step, cell_busy;
  logic [DW-1:0]     d;
  logic [DW+3:0]     d9;
  logic [DW+6:0]     d100;
  logic [DW+7:0]     d169;
  logic [ID_W-1:0]   step_id, mid;
  logic [DW-1:0]     m;
  trk_flags_t        flags;
  logic              keep;
  rsp_t              walk_res;

  assign move       = res_pend_q && (!out_valid_q || rsp.ready);
  assign req.ready  = (state_q == ST_IDLE) && (!res_pend_q || move);
  assign accept     = req.valid && req.ready;
  assign store_full = count_q >= CNT_W'(MAX_POINTS);
  assign wdata      = {req.data.pos_x[CW-1:0], req.data.pos_y[CW-1:0], req.data.obstacle_id};
  assign issue      = (state_q == ST_WALK) && (idx_q < count_q) && !flags.stop;
  assign walk_done  = (state_q == ST_WALK) && !issue && !rdv_q && !cell_busy;
  assign trk_start  = accept && (req.data.command == CMD_CLASSIFY) && req.data.cell_free;

  vecc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && (req.data.command == CMD_APPEND) && !store_full),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  vecc_dist_cell #(
    .CW (CW)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rdv_q),
    .cell_x_i (cell_x_q),
    .cell_y_i (cell_y_q),
    .pt_x_i   (rdata[RAM_W-1 -: CW]),
    .pt_y_i   (rdata[ID_W+CW-1 -: CW]),
    .pt_id_i  (rdata[ID_W-1:0]),
    .valid_o  (step),
    .busy_o   (cell_busy),
    .d_o      (d),
    .d9_o     (d9),
    .d100_o   (d100),
    .d169_o   (d169),
    .id_o     (step_id)
  );

  vecc_track_cell #(
    .CW (CW)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (trk_start),
    .step_i     (step),
    .d_i        (d),
    .d9_i       (d9),
    .d100_i     (d100),
    .d169_i     (d169),
    .id_i       (step_id),
    .clear_sq_i (clear_sq_q),
    .flags_o    (flags),
    .mid_o      (mid),
    .m_o        (m)
  );

  always_comb begin
    keep                     = flags.valid && ((mid == start_id_q) || (mid == goal_id_q));
    walk_res                 = '0;
    walk_res.mark_blocked    = !flags.edge_hit && !keep;
    walk_res.is_edge         = flags.edge_hit;
    walk_res.nearest_valid   = flags.valid;
    walk_res.nearest_id      = flags.valid ? mid : '0;
    walk_res.nearest_dist_sq = flags.valid ? DIST_W'(m) : '0;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    res_d      = res_q;
    res_pend_d = res_pend_q && !move;
    if (issue) begin
      idx_d = idx_q + CNT_W'(1);
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (req.data.command)
            CMD_CLEAR: begin
              count_d    = '0;
              res_pend_d = 1'b1;
            end
            CMD_APPEND: begin
              if (store_full) begin
                res_d.status = 1'b1;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
              res_pend_d = 1'b1;
            end
            CMD_CLASSIFY: begin
              if (req.data.cell_free) begin
                idx_d   = '0;
                state_d = ST_WALK;
              end else begin
                res_pend_d = 1'b1;
              end
            end
            default: begin
              res_pend_d = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          res_d      = walk_res;
          res_pend_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rdv_q       <= 1'b0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      start_id_q  <= START_ID_RST;
      goal_id_q   <= GOAL_ID_RST;
      clear_sq_q  <= CLEAR_SQ_RST;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      rdv_q      <= issue;
      res_pend_q <= res_pend_d;
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_ID: start_id_q <= cfg_data_i[ID_W-1:0];
          CFG_GOAL_ID:  goal_id_q  <= cfg_data_i[ID_W-1:0];
          CFG_CLEAR_SQ: clear_sq_q <= cfg_data_i[DIST_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (trk_start) begin
      cell_x_q <= req.data.pos_x[CW-1:0];
      cell_y_q <= req.data.pos_y[CW-1:0];
    end
    if (move) begin
      out_q <= res_q;
    end
  end

  assign rsp.valid = out_valid_q;
  assign rsp.data  = out_q;
endmodule

FILE: rtl/vecc_checker.sv
// port level checks of the classifier result channel, bound to the top level
// uses vecc_pkg
module vecc_checker
  import vecc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);
  // a result waiting for its sink stays and holds its value
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result dropped or changed while stalled");

  // a dropped append reports nothing but its status
  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status |->
      !rsp_data_i.mark_blocked && !rsp_data_i.is_edge && !rsp_data_i.nearest_valid)
    else $error("dropped append carries classify fields");

  // no nearest point means zero id and distance
  a_nearest_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_data_i.nearest_valid |->
      (rsp_data_i.nearest_id == '0) && (rsp_data_i.nearest_dist_sq == '0))
    else $error("nearest fields set without a nearest point");

  // an edge cell is never blocked and always has a nearest point
  a_edge_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.is_edge |->
      !rsp_data_i.mark_blocked && rsp_data_i.nearest_valid && !rsp_data_i.status)
    else $error("edge cell reported blocked or without nearest point");
endmodule

bind voronoi_edge_cell_classifier vecc_checker u_vecc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_data_i  (rsp.data)
);

FILE: tb/voronoi_edge_cell_classifier_tb.sv
// self-checking testbench for voronoi_edge_cell_classifier: a queue-fed driver, a monitor
// and a predictor of the point list walk that checks every result field
// depends on vecc_pkg, vecc_stream_if and the classifier rtl
module voronoi_edge_cell_classifier_tb;
  import vecc_pkg::*;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  vecc_stream_if #(.T(req_t)) req_ch ();
  vecc_stream_if #(.T(rsp_t)) rsp_ch ();

  voronoi_edge_cell_classifier #(
    .MAX_POINTS(STORE_DEPTH),
    .COORD_BITS(POS_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // predicted block state
  logic [POS_W-1:0]  pt_x  [STORE_DEPTH];
  logic [POS_W-1:0]  pt_y  [STORE_DEPTH];
  logic [ID_W-1:0]   pt_id [STORE_DEPTH];
  int unsigned       pt_count = 0;
  logic [ID_W-1:0]   start_id = START_ID_RST;
  logic [ID_W-1:0]   goal_id  = GOAL_ID_RST;
  logic [DIST_W-1:0] clear_sq = CLEAR_SQ_RST;

  req_t request_q [$];
  rsp_t verdict_q [$];
  rsp_t want;
  rsp_t got;
  int   queued    = 0;
  int   err_cnt   = 0;
  int   idle_pct  = 0;
  int   stall_pct = 0;

  function automatic rsp_t cell_verdict(req_t r);
    rsp_t        v;
    int unsigned dx, dy, d, m;
    logic [ID_W-1:0] mid;
    logic        hit, on_edge, stop, keep;
    v = '0;
    case (r.command)
      CMD_CLEAR: pt_count = 0;
      CMD_APPEND: begin
        if (pt_count < STORE_DEPTH) begin
          pt_x[pt_count]  = r.pos_x;
          pt_y[pt_count]  = r.pos_y;
          pt_id[pt_count] = r.obstacle_id;
          pt_count++;
        end else begin
          v.status = 1'b1;
        end
      end
      CMD_CLASSIFY: begin
        if (r.cell_free) begin
          hit = 1'b0;
          on_edge = 1'b0;
          stop = 1'b0;
          m = 0;
          mid = '0;
          for (int k = 0; k < pt_count && !stop; k++) begin
            dx = (r.pos_x > pt_x[k]) ? r.pos_x - pt_x[k] : pt_x[k] - r.pos_x;
            dy = (r.pos_y > pt_y[k]) ? r.pos_y - pt_y[k] : pt_y[k] - r.pos_y;
            d = dx * dx + dy * dy;
            if (!hit) begin
              hit = 1'b1;
              m = d;
              mid = pt_id[k];
              on_edge = 1'b0;
            end else if (d < m && pt_id[k] == mid) begin
              m = d;
              on_edge = 1'b0;
            end else if (169 * d < 100 * m) begin
              m = d;
              mid = pt_id[k];
              on_edge = 1'b0;
            end else if (pt_id[k] != mid && d < 4 * m && 4 * m < 9 * d) begin
              on_edge = 1'b1;
              // other obstacle inside the clearance ends the walk
              if (d < clear_sq) begin
                on_edge = 1'b0;
                stop = 1'b1;
              end
            end
          end
          keep = hit && (mid == start_id || mid == goal_id);
          v.mark_blocked    = !on_edge && !keep;
          v.is_edge         = on_edge;
          v.nearest_valid   = hit;
          v.nearest_id      = hit ? mid : '0;
          v.nearest_dist_sq = hit ? m[DIST_W-1:0] : '0;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [POS_W-1:0] clip_pos(int v);
    return (v < 0) ? '0 : (v > 255) ? '1 : POS_W'(v);
  endfunction

  function automatic void push_req(logic [1:0] cmd, int x, int y, int id, logic free);
    req_t r;
    r.command     = cmd;
    r.pos_x       = clip_pos(x);
    r.pos_y       = clip_pos(y);
    r.obstacle_id = ID_W'(id);
    r.cell_free   = free;
    request_q = {request_q, r};
    queued++;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_START_ID: start_id = val[ID_W-1:0];
      CFG_GOAL_ID:  goal_id  = val[ID_W-1:0];
      CFG_CLEAR_SQ: clear_sq = val[DIST_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || req_ch.valid || verdict_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) verdict_q = {verdict_q, cell_verdict(req_ch.data)};
      if (!req_ch.valid || req_ch.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.data  <= request_q.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (verdict_q.size() == 0) begin
          if (err_cnt < 10) $display("unexpected result %p", got);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (got.status !== want.status || got.mark_blocked !== want.mark_blocked ||
              got.is_edge !== want.is_edge || got.nearest_valid !== want.nearest_valid ||
              got.nearest_id !== want.nearest_id ||
              got.nearest_dist_sq !== want.nearest_dist_sq) begin
            if (err_cnt < 10) begin
              $display("mismatch exp st=%0d blk=%0d edge=%0d vld=%0d id=%0d dsq=%0d",
                       want.status, want.mark_blocked, want.is_edge, want.nearest_valid,
                       want.nearest_id, want.nearest_dist_sq);
              $display("         got st=%0d blk=%0d edge=%0d vld=%0d id=%0d dsq=%0d",
                       got.status, got.mark_blocked, got.is_edge, got.nearest_valid,
                       got.nearest_id, got.nearest_dist_sq);
            end
            err_cnt++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 3000000);
    $display("[voronoi_edge_cell_classifier] ERROR");
    $finish;
  end

  initial begin
    int base, nclust, spread, npts, ncells, a, b, c, mode;
    int cx [4];
    int cy [4];
    int cid [4];
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty list, extremes, hysteresis rules, clearance stop
    push_req(CMD_CLASSIFY, 10, 10, 0, 1'b1);
    push_req(CMD_NONE, 255, 255, 255, 1'b1);
    push_req(CMD_APPEND, 0, 0, 5, 1'b0);
    push_req(CMD_CLASSIFY, 255, 255, 0, 1'b1);
    push_req(CMD_CLASSIFY, 0, 0, 0, 1'b0);
    push_req(CMD_CLEAR, 255, 255, 255, 1'b1);
    push_req(CMD_APPEND, 10, 10, 7, 1'b1);
    push_req(CMD_APPEND, 12, 10, 7, 1'b1);
    push_req(CMD_APPEND, 20, 10, 9, 1'b1);
    push_req(CMD_APPEND, 15, 10, 9, 1'b1);
    push_req(CMD_CLASSIFY, 16, 10, 0, 1'b1);
    push_req(CMD_CLASSIFY, 14, 10, 0, 1'b1);
    push_req(CMD_CLASSIFY, 13, 10, 0, 1'b1);
    push_req(CMD_APPEND, 30, 30, 1, 1'b1);
    push_req(CMD_APPEND, 34, 31, 2, 1'b1);
    push_req(CMD_APPEND, 33, 31, 8, 1'b1);
    push_req(CMD_CLASSIFY, 32, 30, 0, 1'b1);
    push_req(CMD_CLASSIFY, 33, 30, 0, 1'b1);
    push_req(CMD_CLASSIFY, 31, 30, 0, 1'b1);
    push_req(CMD_CLASSIFY, 200, 200, 0, 1'b1);
    push_req(CMD_CLEAR, 0, 0, 0, 1'b0);
    push_req(CMD_APPEND, 255, 0, 255, 1'b1);
    push_req(CMD_CLASSIFY, 0, 255, 0, 1'b1);
    push_req(CMD_APPEND, 0, 255, 0, 1'b1);
    push_req(CMD_CLASSIFY, 0, 255, 0, 1'b1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_reg(CFG_START_ID, 17'd0);
          write_reg(CFG_GOAL_ID, 17'd255);
          write_reg(CFG_CLEAR_SQ, 17'd0);
        end
        1: begin
          write_reg(CFG_CLEAR_SQ, 17'd131071);
          write_reg(CFG_START_ID, 17'h1FF03);
        end
        2: begin
          write_reg(CFG_GOAL_ID, 17'h10004);
          write_reg(CFG_CLEAR_SQ, 17'd16);
        end
        3: begin
          write_reg(CFG_UNUSED, 17'h1ABCD);
          write_reg(CFG_CLEAR_SQ, 17'd1);
        end
        default: begin
          write_reg(CFG_START_ID, CFG_W'($urandom_range(255)));
          write_reg(CFG_GOAL_ID, CFG_W'($urandom_range(255)));
          write_reg(CFG_CLEAR_SQ, $urandom_range(1) ? CFG_W'($urandom_range(131071))
                                                    : CFG_W'($urandom_range(200)));
        end
      endcase
      mode = p % 4;
      idle_pct  = (mode == 1) ? 52 : (mode == 3) ? 7 : 0;
      stall_pct = (mode == 2) ? 52 : (mode == 3) ? 7 : 0;

      base = queued;
      while (queued - base < 62) begin
        if ($urandom_range(99) < 15) begin
          push_req(2'($urandom_range(3)), $urandom_range(255), $urandom_range(255),
                   $urandom_range(255), 1'($urandom_range(1)));
        end else begin
          if ($urandom_range(4) != 0)
            push_req(CMD_CLEAR, $urandom_range(255), $urandom_range(255),
                     $urandom_range(255), 1'($urandom_range(1)));
          nclust = $urandom_range(1, 4);
          spread = $urandom_range(1, 12);
          for (int k = 0; k < nclust; k++) begin
            cx[k] = $urandom_range(255);
            cy[k] = $urandom_range(255);
            case ($urandom_range(4))
              0: cid[k] = start_id;
              1: cid[k] = goal_id;
              default: cid[k] = $urandom_range(255);
            endcase
          end
          npts = $urandom_range(1, 20);
          for (int k = 0; k < npts; k++) begin
            c = $urandom_range(nclust - 1);
            push_req(CMD_APPEND, cx[c] + int'($urandom_range(2 * spread)) - spread,
                     cy[c] + int'($urandom_range(2 * spread)) - spread, cid[c],
                     1'($urandom_range(1)));
          end
          // cells between cluster pairs to hit near ties
          ncells = $urandom_range(1, 6);
          for (int k = 0; k < ncells; k++) begin
            a = $urandom_range(nclust - 1);
            b = $urandom_range(nclust - 1);
            push_req(CMD_CLASSIFY,
                     (cx[a] + cx[b]) / 2 + int'($urandom_range(2 * spread)) - spread,
                     (cy[a] + cy[b]) / 2 + int'($urandom_range(2 * spread)) - spread,
                     $urandom_range(255), $urandom_range(9) != 0);
          end
        end
      end
      wait_drained();
    end

    // occupied cell, unused command, classify after clear
    idle_pct  = 7;
    stall_pct = 7;
    push_req(CMD_CLASSIFY, 128, 128, 0, 1'b0);
    push_req(CMD_NONE, 0, 0, 0, 1'b0);
    push_req(CMD_CLEAR, 255, 255, 255, 1'b0);
    push_req(CMD_CLASSIFY, 128, 128, 0, 1'b1);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[voronoi_edge_cell_classifier] OK");
    end else begin
      $display("[voronoi_edge_cell_classifier] ERROR");
    end
    $finish;
  end

endmodule
